[hw/rtl/dirty_entry_round_robin_scanner_unit_assert.svh]
// assertion macros for the dirty entry scanner
// used by the top level, no other dependencies
`ifndef DIRTY_ENTRY_ROUND_ROBIN_SCANNER_UNIT_ASSERT_SVH
`define DIRTY_ENTRY_ROUND_ROBIN_SCANNER_UNIT_ASSERT_SVH

// clocked assertion with explicit clock and active-low reset
`define DERRS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion on clk_i / rst_ni
`define DERRS_ASSERT(lbl, prop, msg) `DERRS_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[hw/rtl/derrs_pkg.sv]
// types shared by the dirty entry scanner
// no dependencies
package derrs_pkg;

  typedef enum logic [1:0] {
    KIND_OBSERVE  = 2'd0,
    KIND_NEXT     = 2'd1,
    KIND_COMPLETE = 2'd2,
    KIND_MARK_ALL = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_CMP
  } state_e;

  typedef struct packed {
    logic       accepted;
    logic       found;
    logic [7:0] deck;
    logic [7:0] id;
    logic [7:0] value;
  } result_t;

endpackage

[hw/rtl/derrs_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module derrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/dirty_entry_round_robin_scanner_unit.sv]
// dirty entry round robin scanner, top level
// depends on derrs_pkg, derrs_ram and the assertion macro header
//
//   channel  | handshake               | fields
//   ---------+-------------------------+---------------------------------------------
//   command  | start_i, busy_o         | kind_i deck_index_i entry_id_i led_value_i sent_ok_i
//   result   | valid_o (1-cycle strobe)| accepted_o found_o out_deck_o out_id_o out_value_o
//            |                         | retry_total_o
//
// observe, mark-all and failed or ignored complete: result in the cycle after the transfer
// complete on a known slot: the value ram read is registered, then compared in ST_CMP
// next: ST_SCAN visits one slot per cycle via the single scan step unit, up to
//   NUM_DECKS*IDS_PER_DECK slots, then ST_FETCH takes the value ram read on a hit
// reset clears known and dirty flops, cursor and retry counter at once; the value ram is
//   only read for known slots and needs no clearing
// the receiver cannot stall; busy_o is high while a command is in flight
`include "dirty_entry_round_robin_scanner_unit_assert.svh"

module dirty_entry_round_robin_scanner_unit #(
  parameter int NUM_DECKS    = 2,
  parameter int IDS_PER_DECK = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  deck_index_i,
  input  logic [7:0]  entry_id_i,
  input  logic [7:0]  led_value_i,
  input  logic        sent_ok_i,
  output logic        valid_o,
  output logic        accepted_o,
  output logic        found_o,
  output logic [7:0]  out_deck_o,
  output logic [7:0]  out_id_o,
  output logic [7:0]  out_value_o,
  output logic [31:0] retry_total_o
);

  import derrs_pkg::*;

  localparam int SLOT_COUNT = NUM_DECKS * IDS_PER_DECK;
  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int DECK_W = (NUM_DECKS > 1) ? $clog2(NUM_DECKS) : 1;
  localparam int ID_W   = (IDS_PER_DECK > 1) ? $clog2(IDS_PER_DECK) : 1;

  typedef struct packed {
    logic [DECK_W-1:0] deck;
    logic [ID_W-1:0]   id;
    logic [IDX_W-1:0]  flat;
  } slot_t;

  state_e                 state_q, state_d;
  slot_t                  pos_q, pos_d, ptr_q, ptr_d, pos_inc;
  logic [IDX_W-1:0]       cnt_q, cnt_d;
  logic [SLOT_COUNT-1:0]  known_q, known_d, dirty_q, dirty_d;
  logic [31:0]            retry_q, retry_d;
  logic [IDX_W-1:0]       cmp_flat_q, cmp_flat_d;
  logic [7:0]             cmp_val_q, cmp_val_d;
  logic                   valid_q, valid_d;
  result_t                res_q, res_d;

  logic                   in_range;
  logic [IDX_W-1:0]       in_flat;
  logic                   ram_we, ram_re;
  logic [IDX_W-1:0]       ram_raddr;
  logic [7:0]             ram_rdata;

  assign in_range = (deck_index_i < 8'(NUM_DECKS)) && (entry_id_i < 8'(IDS_PER_DECK));
  assign in_flat  = IDX_W'(deck_index_i) * IDX_W'(IDS_PER_DECK) + IDX_W'(entry_id_i);

  // shared scan step unit: advance a slot position round robin
  always_comb begin
    pos_inc = pos_q;
    pos_inc.flat = (pos_q.flat == IDX_W'(SLOT_COUNT - 1)) ? '0 : pos_q.flat + 1'b1;
    if (pos_q.id == ID_W'(IDS_PER_DECK - 1)) begin
      pos_inc.id   = '0;
      pos_inc.deck = (pos_q.deck == DECK_W'(NUM_DECKS - 1)) ? '0 : pos_q.deck + 1'b1;
    end else begin
      pos_inc.id = pos_q.id + 1'b1;
    end
  end

  derrs_ram #(
    .WIDTH(8),
    .DEPTH(SLOT_COUNT)
  ) u_value_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(in_flat),
    .wdata_i(led_value_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    known_d    = known_q;
    dirty_d    = dirty_q;
    retry_d    = retry_q;
    cmp_flat_d = cmp_flat_q;
    cmp_val_d  = cmp_val_q;
    valid_d    = 1'b0;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = pos_q.flat;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          res_d = '0;
          case (kind_e'(kind_i))
            KIND_OBSERVE: begin
              valid_d = 1'b1;
              if (in_range) begin
                ram_we           = 1'b1;
                known_d[in_flat] = 1'b1;
                dirty_d[in_flat] = 1'b1;
                res_d.accepted   = 1'b1;
              end
            end
            KIND_NEXT: begin
              pos_d   = ptr_q;
              cnt_d   = '0;
              state_d = ST_SCAN;
            end
            KIND_COMPLETE: begin
              if (in_range && !sent_ok_i) begin
                retry_d = retry_q + 32'd1;
                valid_d = 1'b1;
              end else if (in_range && known_q[in_flat]) begin
                ram_re     = 1'b1;
                ram_raddr  = in_flat;
                cmp_flat_d = in_flat;
                cmp_val_d  = led_value_i;
                state_d    = ST_CMP;
              end else begin
                valid_d = 1'b1;
              end
            end
            KIND_MARK_ALL: begin
              dirty_d = dirty_q | known_q;
              valid_d = 1'b1;
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (known_q[pos_q.flat] && dirty_q[pos_q.flat]) begin
          ram_re  = 1'b1;
          state_d = ST_FETCH;
        end else if (cnt_q == IDX_W'(SLOT_COUNT - 1)) begin
          res_d   = '0;
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          pos_d = pos_inc;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FETCH: begin
        res_d.accepted = 1'b0;
        res_d.found    = 1'b1;
        res_d.deck     = 8'(pos_q.deck);
        res_d.id       = 8'(pos_q.id);
        res_d.value    = ram_rdata;
        ptr_d          = pos_inc;
        valid_d        = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_CMP: begin
        if (ram_rdata == cmp_val_q) begin
          dirty_d[cmp_flat_q] = 1'b0;
        end
        res_d   = '0;
        valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
      cnt_q   <= '0;
      known_q <= '0;
      dirty_q <= '0;
      retry_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      known_q <= known_d;
      dirty_q <= dirty_d;
      retry_q <= retry_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    cmp_flat_q <= cmp_flat_d;
    cmp_val_q  <= cmp_val_d;
    res_q      <= res_d;
  end

  assign busy_o        = (state_q != ST_IDLE);
  assign valid_o       = valid_q;
  assign accepted_o    = res_q.accepted;
  assign found_o       = res_q.found;
  assign out_deck_o    = res_q.deck;
  assign out_id_o      = res_q.id;
  assign out_value_o   = res_q.value;
  assign retry_total_o = retry_q;

  `DERRS_ASSERT(a_fetch_reports_hit, state_q == ST_FETCH |=> valid_o && found_o,
                "fetch did not report a found slot")
  `DERRS_ASSERT(a_observe_in_range, start_i && !busy_o && kind_i == KIND_OBSERVE && in_range
                |=> valid_o && accepted_o, "in-range observe not accepted")
  `DERRS_ASSERT(a_retry_step, retry_q != $past(retry_q) |-> retry_q == $past(retry_q) + 32'd1,
                "retry counter moved by more than one")
  `DERRS_ASSERT(a_result_when_idle, valid_o |-> !busy_o, "result strobe while busy")

endmodule
